// ----- hdl/cww_pkg.sv -----
`default_nettype none
package cww_pkg;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned WORD_W     = 72;
  localparam int unsigned DIST_W     = 50;
  localparam int unsigned ENTRY_W    = 10;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PARKING   = 2'd0,
    REG_MAX_DIST  = 2'd1,
    REG_LANE_DIST = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QSTART,
    ST_SCAN,
    ST_FIN,
    ST_WIN,
    ST_ERD,
    ST_ELD
  } state_t;

  localparam logic signed [8:0] STATIC_MODE = -9'sd2;

  typedef struct packed {
    logic              parking;
    logic signed [9:0] match;
    logic [7:0]        target;
  } qual_t;

endpackage
`default_nettype wire

// ----- hdl/cww_mem.sv -----
`default_nettype none
module cww_mem
  import cww_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cww_dist.sv -----
`default_nettype none
module cww_dist
  import cww_pkg::*;
#(
  parameter int unsigned EW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [EW-1:0]     in_idx,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [23:0]       px,
  input  wire logic [23:0]       py,
  input  wire qual_t             qual,
  output logic                   out_valid,
  output logic      [EW-1:0]     out_idx,
  output logic                   out_ok,
  output logic      [DIST_W-1:0] out_dist,
  output logic                   busy
);

  logic signed [24:0] dx, dy;
  logic signed [9:0]  diff;
  logic [7:0]         m;
  logic               ok;

  logic              v1, v2;
  logic [EW-1:0]     idx1, idx2;
  logic              ok1, ok2;
  logic [24:0]       ax, ay;
  logic [DIST_W-1:0] sx, sy;

  always_comb begin
    m    = word[71:64];
    dx   = {px[23], px} - {word[23], word[23:0]};
    dy   = {py[23], py} - {word[47], word[47:24]};
    diff = signed'({2'b00, m}) - signed'({2'b00, qual.target});
    if (qual.parking) begin
      ok = (signed'({2'b00, m}) == qual.match);
    end else begin
      ok = (diff >= -10'sd1) && (diff <= 10'sd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    ax       <= dx[24] ? 25'(-dx) : 25'(dx);
    ay       <= dy[24] ? 25'(-dy) : 25'(dy);
    ok1      <= ok;
    idx1     <= in_idx;
    sx       <= ax * ax;
    sy       <= ay * ay;
    ok2      <= ok1;
    idx2     <= idx1;
    out_dist <= sx + sy;
    out_ok   <= ok2;
    out_idx  <= idx2;
  end

  assign busy = v1 | v2 | out_valid;

endmodule
`default_nettype wire

// ----- hdl/closest_waypoint_window.sv -----
`default_nettype none
// Nearest-waypoint search over lanes of stored waypoints, followed by a window
// of up to WINDOW waypoints starting at the closest entry. A pose query scans
// the N waypoints of the active lane, one read a cycle from the single
// waypoint memory port, then reads each window beat in ST_ERD and sends it
// from ST_ELD once the output register is free. Queries are handled one at a
// time; the output register lets the next beat be accepted while the final
// result still waits.
module closest_waypoint_window
  import cww_pkg::*;
#(
  parameter int unsigned LANES     = 4,
  parameter int unsigned WAYPOINTS = 1024,
  parameter int unsigned WINDOW    = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // mode, lane, pos_x, pos_y, mission, wp_number, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // entry_pos, out_number, out_x, out_y, out_mission, on_lane, found, zero pad
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  localparam int unsigned DEPTH = LANES * WAYPOINTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CW    = $clog2(WAYPOINTS + 1);
  localparam int unsigned EW    = $clog2(WAYPOINTS);
  localparam int unsigned NW    = $clog2(WINDOW + 1);

  mode_t       in_mode;
  logic [1:0]  in_lane;
  logic [23:0] in_x, in_y;
  logic [7:0]  in_mission;
  logic [15:0] in_number;

  assign in_mode    = mode_t'(s_tdata[1:0]);
  assign in_lane    = s_tdata[3:2];
  assign in_x       = s_tdata[27:4];
  assign in_y       = s_tdata[51:28];
  assign in_mission = s_tdata[59:52];
  assign in_number  = s_tdata[75:60];

  state_t state, state_next;

  logic signed [8:0] park_level;
  logic [15:0]       max_search_dist, on_lane_dist;

  logic [CW-1:0]     lane_count [LANES];
  logic [LW-1:0]     active_lane;
  logic [1:0]        target_lane;
  logic [7:0]        target_mission;
  logic [EW-1:0]     closest_entry;
  logic              on_lane_flag;

  logic [23:0]       qx, qy;
  qual_t             qual;
  logic [AW-1:0]     base;
  logic [CW-1:0]     cnt, scan_i, entry;
  logic [NW-1:0]     win_n, win_k;
  logic [DIST_W-1:0] best;
  logic [31:0]       lane_sq;
  logic [EW-1:0]     best_i;
  logic              found;

  logic              rd_valid;
  logic [EW-1:0]     rd_idx;

  logic              s_acc, out_free, load_ok;
  logic [LW-1:0]     cnt_sel;
  logic [CW-1:0]     cnt_rd, remain;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              d_valid, d_ok, d_busy;
  logic [EW-1:0]     d_idx;
  logic [DIST_W-1:0] d_dist;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign cnt_sel = (state == ST_IDLE) ? LW'(in_lane) : active_lane;
  assign cnt_rd  = lane_count[cnt_sel];
  assign load_ok = (32'(in_lane) < LANES) && (cnt_rd < CW'(WAYPOINTS));
  assign remain  = cnt - CW'(closest_entry);

  cww_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_mission, in_number, in_y, in_x}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cww_dist #(.EW(EW)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .word      (mem_rdata),
    .px        (qx),
    .py        (qy),
    .qual      (qual),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .out_ok    (d_ok),
    .out_dist  (d_dist),
    .busy      (d_busy)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_acc && in_mode == MODE_QUERY) state_next = ST_QSTART;
      ST_QSTART: state_next = ST_SCAN;
      ST_SCAN:   if (scan_i == cnt && !rd_valid && !d_busy) state_next = ST_FIN;
      ST_FIN:    state_next = ST_WIN;
      ST_WIN:    state_next = (CW'(closest_entry) >= cnt) ? ST_IDLE : ST_ERD;
      ST_ERD:    state_next = ST_ELD;
      ST_ELD: begin
        if (out_free) begin
          state_next = (NW'(win_k + 1'b1) == win_n) ? ST_IDLE : ST_ERD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(LW'(in_lane)) * AW'(WAYPOINTS) + AW'(cnt_rd);
    mem_raddr = base + AW'(entry);
    unique case (state)
      ST_IDLE: mem_we = s_acc && in_mode == MODE_LOAD && load_ok;
      ST_SCAN: begin
        mem_re    = (scan_i != cnt);
        mem_raddr = base + AW'(scan_i);
      end
      ST_ERD:  mem_re = 1'b1;
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      park_level      <= -9'sd1;
      max_search_dist <= 16'd1000;
      on_lane_dist    <= 16'd80;
      for (int l = 0; l < LANES; l++) begin
        lane_count[l] <= '0;
      end
      active_lane     <= '0;
      target_lane     <= '0;
      target_mission  <= '0;
      closest_entry   <= '0;
      on_lane_flag    <= 1'b0;
      rd_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_SCAN) && (scan_i != cnt);
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_PARKING:   park_level      <= signed'(cfg_data[8:0]);
          REG_MAX_DIST:  max_search_dist <= cfg_data;
          REG_LANE_DIST: on_lane_dist    <= cfg_data;
          default:       ;
        endcase
      end
      if (state == ST_ELD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (in_mode)
              MODE_LOAD: if (load_ok) lane_count[LW'(in_lane)] <= cnt_rd + 1'b1;
              MODE_TARGET: begin
                target_lane    <= in_lane;
                target_mission <= in_mission;
              end
              MODE_QUERY: begin
                if (32'(target_lane) != 32'(active_lane) && park_level >= STATIC_MODE
                    && 32'(target_lane) < LANES) begin
                  active_lane <= LW'(target_lane);
                end
              end
              default: ;
            endcase
          end
        end
        ST_FIN: begin
          if (found) begin
            closest_entry <= best_i;
            on_lane_flag  <= (best < DIST_W'(lane_sq));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= EW'(scan_i);
    unique case (state)
      ST_IDLE: begin
        qx <= in_x;
        qy <= in_y;
      end
      ST_QSTART: begin
        cnt          <= cnt_rd;
        base         <= AW'(active_lane) * AW'(WAYPOINTS);
        scan_i       <= '0;
        best         <= DIST_W'(32'(max_search_dist) * 32'(max_search_dist));
        lane_sq      <= 32'(on_lane_dist) * 32'(on_lane_dist);
        found        <= 1'b0;
        qual.parking <= park_level > STATIC_MODE;
        qual.match   <= 10'(park_level) + 10'sd1;
        qual.target  <= target_mission;
      end
      ST_SCAN: begin
        if (scan_i != cnt) begin
          scan_i <= scan_i + 1'b1;
        end
        if (d_valid && d_ok && d_dist < best) begin
          best   <= d_dist;
          best_i <= d_idx;
          found  <= 1'b1;
        end
      end
      ST_WIN: begin
        entry <= CW'(closest_entry);
        win_k <= '0;
        win_n <= (remain > CW'(WINDOW)) ? NW'(WINDOW) : NW'(remain);
      end
      ST_ELD: begin
        if (out_free) begin
          m_tdata <= {4'b0000, found, on_lane_flag, mem_rdata[71:64], mem_rdata[47:24],
                      mem_rdata[23:0], mem_rdata[63:48], ENTRY_W'(entry)};
          m_tlast <= (NW'(win_k + 1'b1) == win_n);
          entry   <= entry + 1'b1;
          win_k   <= win_k + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- verif/closest_waypoint_window_tb.sv -----
`timescale 1ns / 1ps
module closest_waypoint_window_tb;
  import cww_pkg::*;

  localparam int unsigned LANES      = 4;
  localparam int unsigned WAYPOINTS  = 1024;
  localparam int unsigned WINDOW     = 30;
  localparam int unsigned SETTLE     = 1200;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    mode_t            mode;
    logic [1:0]       lane;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [7:0]       mission;
    logic [15:0]      number;
  } beat_in_t;

  typedef struct {
    logic [9:0]         entry;
    logic [15:0]        number;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [7:0]         mission;
    logic               on_lane;
    logic               found;
    logic               last;
  } window_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  closest_waypoint_window u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow state of the waypoint search.
  logic signed [23:0] wp_x [LANES][WAYPOINTS];
  logic signed [23:0] wp_y [LANES][WAYPOINTS];
  logic [7:0]         wp_mis [LANES][WAYPOINTS];
  logic [15:0]        wp_num [LANES][WAYPOINTS];
  int unsigned        lane_fill [LANES];
  int unsigned        cur_lane, want_lane, want_mission, near_entry;
  logic               near_flag;
  int                 parking;
  longint unsigned    search_dist, lane_dist;

  beat_in_t     pending_beats [$];
  beat_in_t     cur_beat;
  window_beat_t window_due [$];
  int           err_count = 0;
  longint unsigned cycles = 0;
  bit           quiet = 0;
  bit           hold_send = 0;
  int           hold_token = 0;
  int           hold_seen = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_long = 0;

  function automatic longint unsigned sq_dist(logic signed [23:0] ax, logic signed [23:0] ay,
                                              logic signed [23:0] bx, logic signed [23:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  task automatic predict_window(beat_in_t b);
    longint unsigned best, d;
    bit hit;
    int unsigned best_i, cnt, n, e;
    int diff;
    bit ok;
    window_beat_t w;
    case (b.mode)
      MODE_LOAD: begin
        if (lane_fill[b.lane] < WAYPOINTS) begin
          wp_x[b.lane][lane_fill[b.lane]] = b.px;
          wp_y[b.lane][lane_fill[b.lane]] = b.py;
          wp_mis[b.lane][lane_fill[b.lane]] = b.mission;
          wp_num[b.lane][lane_fill[b.lane]] = b.number;
          lane_fill[b.lane]++;
        end
      end
      MODE_TARGET: begin
        want_lane = b.lane;
        want_mission = b.mission;
      end
      MODE_QUERY: begin
        if (want_lane != cur_lane && parking >= -2 && want_lane < LANES) cur_lane = want_lane;
        cnt = lane_fill[cur_lane];
        best = search_dist * search_dist;
        hit = 0;
        best_i = 0;
        for (int unsigned i = 0; i < cnt; i++) begin
          d = sq_dist(b.px, b.py, wp_x[cur_lane][i], wp_y[cur_lane][i]);
          if (parking > -2) ok = (int'(wp_mis[cur_lane][i]) == parking + 1);
          else begin
            diff = int'(wp_mis[cur_lane][i]) - int'(want_mission);
            ok = (diff >= -1 && diff <= 1);
          end
          if (ok && d < best) begin
            best = d;
            best_i = i;
            hit = 1;
          end
        end
        if (hit) begin
          near_entry = best_i;
          near_flag = (best < lane_dist * lane_dist);
        end
        if (near_entry < cnt) begin
          n = cnt - near_entry;
          if (n > WINDOW) n = WINDOW;
          for (int unsigned i = 0; i < n; i++) begin
            e = near_entry + i;
            w.entry = e[9:0];
            w.number = wp_num[cur_lane][e];
            w.x = wp_x[cur_lane][e];
            w.y = wp_y[cur_lane][e];
            w.mission = wp_mis[cur_lane][e];
            w.on_lane = near_flag;
            w.found = hit;
            w.last = (i + 1 == n);
            window_due.insert(window_due.size(), w);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("closest_waypoint_window test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_window(cur_beat);
      nxt_valid = s_tvalid && !s_tready;
      if (!nxt_valid) begin
        if (tx_gap > 0) tx_gap--;
        else if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 16) - 1;
        else if (!hold_send && pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          s_tdata <= {4'b0, cur_beat.number, cur_beat.mission, cur_beat.py, cur_beat.px,
                      cur_beat.lane, cur_beat.mode};
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    window_beat_t w;
    logic nxt_ready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (window_due.size() == 0) begin
          $error("result beat with nothing expected: %h", m_tdata);
          err_count++;
        end else begin
          w = window_due.pop_front();
          if (m_tdata[9:0] != w.entry) begin
            $error("entry_pos expected %0d actual %0d", w.entry, m_tdata[9:0]);
            err_count++;
          end
          if (m_tdata[25:10] != w.number) begin
            $error("out_number expected %0d actual %0d", w.number, m_tdata[25:10]);
            err_count++;
          end
          if ($signed(m_tdata[49:26]) != w.x) begin
            $error("out_x expected %0d actual %0d", w.x, $signed(m_tdata[49:26]));
            err_count++;
          end
          if ($signed(m_tdata[73:50]) != w.y) begin
            $error("out_y expected %0d actual %0d", w.y, $signed(m_tdata[73:50]));
            err_count++;
          end
          if (m_tdata[81:74] != w.mission) begin
            $error("out_mission expected %0d actual %0d", w.mission, m_tdata[81:74]);
            err_count++;
          end
          if (m_tdata[82] != w.on_lane) begin
            $error("on_lane expected %0d actual %0d", w.on_lane, m_tdata[82]);
            err_count++;
          end
          if (m_tdata[83] != w.found) begin
            $error("found expected %0d actual %0d", w.found, m_tdata[83]);
            err_count++;
          end
          if (m_tlast != w.last) begin
            $error("last expected %0d actual %0d", w.last, m_tlast);
            err_count++;
          end
        end
      end
      nxt_ready = 1'b0;
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        rx_long = 600;
      end
      if (rx_long > 0) rx_long--;
      else if (rx_gap > 0) rx_gap--;
      else if (!quiet && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 16) - 1;
      else nxt_ready = 1'b1;
      m_tready <= nxt_ready;
    end
  end

  task automatic push_beat(mode_t md, logic [1:0] ln, logic signed [23:0] x,
                           logic signed [23:0] y, logic [7:0] ms, logic [15:0] num);
    beat_in_t b;
    b.mode = md;
    b.lane = ln;
    b.px = x;
    b.py = y;
    b.mission = ms;
    b.number = num;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic settle();
    while (pending_beats.size() > 0 || s_tvalid || window_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PARKING: parking = $signed(val[8:0]);
      REG_MAX_DIST: search_dist = 64'(val);
      REG_LANE_DIST: lane_dist = 64'(val);
      default: ;
    endcase
  endtask

  task automatic random_beats(int count);
    int r;
    logic signed [23:0] x, y;
    logic [7:0] ms;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        x = 24'($urandom);
        y = 24'($urandom);
      end else begin
        x = 24'($signed($urandom_range(0, 1600)) - 800);
        y = 24'($signed($urandom_range(0, 1600)) - 800);
      end
      ms = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      r = $urandom_range(0, 99);
      if (r < 40) push_beat(MODE_LOAD, 2'($urandom_range(0, 2)), x, y, ms, 16'($urandom));
      else if (r < 55) push_beat(MODE_TARGET, 2'($urandom), x, y, ms, 16'($urandom));
      else if (r < 95) push_beat(MODE_QUERY, 2'($urandom), x, y, 8'($urandom), 16'($urandom));
      else push_beat(MODE_NONE, 2'($urandom), x, y, ms, 16'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < LANES; i++) lane_fill[i] = 0;
    cur_lane = 0;
    want_lane = 0;
    want_mission = 0;
    near_entry = 0;
    near_flag = 0;
    parking = -1;
    search_dist = 1000;
    lane_dist = 80;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: only mission zero qualifies.
    push_beat(MODE_QUERY, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'd0);
    push_beat(MODE_LOAD, 2'd0, -24'sd8388608, 24'sd8388607, 8'd0, 16'd0);
    push_beat(MODE_LOAD, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'hFFFF);
    push_beat(MODE_LOAD, 2'd0, 24'sd10, 24'sd10, 8'd255, 16'd1234);
    push_beat(MODE_LOAD, 2'd0, -24'sd5, 24'sd3, 8'd0, 16'd77);
    push_beat(MODE_LOAD, 2'd0, 24'sd500, -24'sd400, 8'd1, 16'd78);
    push_beat(MODE_QUERY, 2'd3, 24'sd8388607, -24'sd8388608, 8'hFF, 16'hFFFF);
    push_beat(MODE_QUERY, 2'd0, 24'sd1, 24'sd1, 8'd0, 16'd0);
    push_beat(MODE_NONE, 2'd3, 24'sd1, 24'sd1, 8'hFF, 16'hFFFF);
    push_beat(MODE_TARGET, 2'd1, 24'sd0, 24'sd0, 8'd5, 16'd0);
    push_beat(MODE_QUERY, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'd0);
    push_beat(MODE_LOAD, 2'd1, 24'sd20, 24'sd0, 8'd0, 16'd5);
    push_beat(MODE_QUERY, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'd0);
    settle();

    write_reg(REG_PARKING, 16'(-9'sd2));
    write_reg(REG_MAX_DIST, 16'hFFFF);
    write_reg(REG_LANE_DIST, 16'hFFFF);
    push_beat(MODE_TARGET, 2'd0, 24'sd0, 24'sd0, 8'd254, 16'd0);
    push_beat(MODE_QUERY, 2'd0, 24'sd9, 24'sd9, 8'd0, 16'd0);
    push_beat(MODE_TARGET, 2'd0, 24'sd0, 24'sd0, 8'd2, 16'd0);
    push_beat(MODE_QUERY, 2'd0, 24'sd400, -24'sd300, 8'd0, 16'd0);
    settle();

    write_reg(REG_PARKING, 16'(-9'sd8));
    write_reg(REG_MAX_DIST, 16'd0);
    write_reg(REG_LANE_DIST, 16'd0);
    push_beat(MODE_TARGET, 2'd1, 24'sd0, 24'sd0, 8'd0, 16'd0);
    push_beat(MODE_QUERY, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'd0);
    settle();

    write_reg(REG_PARKING, 16'(9'sd254));
    write_reg(REG_MAX_DIST, 16'd1000);
    write_reg(REG_LANE_DIST, 16'd80);
    push_beat(MODE_QUERY, 2'd0, 24'sd10, 24'sd12, 8'd0, 16'd0);
    settle();

    // A long lane three, so that the window is cut to its full length.
    write_reg(REG_PARKING, 16'(-9'sd1));
    push_beat(MODE_LOAD, 2'd3, 24'sd0, 24'sd0, 8'd0, 16'd4321);
    push_beat(MODE_LOAD, 2'd3, 24'sd1, 24'sd1, 8'd0, 16'd999);
    for (int i = 0; i < 40; i++)
      push_beat(MODE_LOAD, 2'd3, 24'(3000000 + i), 24'($urandom), 8'd200, 16'($urandom));
    push_beat(MODE_TARGET, 2'd3, 24'sd0, 24'sd0, 8'd0, 16'd0);
    push_beat(MODE_QUERY, 2'd0, 24'sd2, 24'sd2, 8'd0, 16'd0);
    push_beat(MODE_TARGET, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'd0);
    settle();

    write_reg(REG_PARKING, 16'(-9'sd2));
    write_reg(REG_MAX_DIST, 16'd1000);
    write_reg(REG_LANE_DIST, 16'd300);
    random_beats(30);
    hold_token++;
    for (int i = 0; i < 20; i++) push_beat(MODE_QUERY, 2'd0, 24'sd0, 24'sd0, 8'd0, 16'd0);
    random_beats(15);
    while (pending_beats.size() > 0 || s_tvalid) @(posedge clk);
    hold_send = 1;
    while (window_due.size() > 0) @(posedge clk);
    hold_send = 0;
    random_beats(25);
    settle();

    write_reg(REG_PARKING, 16'(9'sd0));
    write_reg(REG_MAX_DIST, 16'd2000);
    random_beats(25);
    settle();

    quiet = 1;
    write_reg(REG_PARKING, 16'(-9'sd1));
    write_reg(REG_LANE_DIST, 16'd80);
    random_beats(25);
    settle();

    if (err_count == 0 && window_due.size() == 0) begin
      $display("closest_waypoint_window test passed");
    end else begin
      $display("closest_waypoint_window test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cww_pkg.sv
hdl/cww_mem.sv
hdl/cww_dist.sv
hdl/closest_waypoint_window.sv
verif/closest_waypoint_window_tb.sv
